[rtl/core/awle_pkg.sv]
`timescale 1ns / 1ps
package awle_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int LEVEL_W   = 22;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 32;
  localparam int RANGE_W   = SAMPLE_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_STEP   = 2'd2;

  localparam logic [1:0] MODE_DIFF  = 2'd0;
  localparam logic [1:0] MODE_RANGE = 2'd1;
  localparam logic [1:0] MODE_MIX   = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // running extremes: set 0 covers ages 0..W-1, set 1 covers ages 1..W
  typedef struct packed {
    sample_t lo0;
    sample_t hi0;
    sample_t lo1;
    sample_t hi1;
  } mm_t;

  localparam mm_t MM_INIT = '{
    lo0: 16'sh7FFF,
    hi0: 16'sh8000,
    lo1: 16'sh7FFF,
    hi1: 16'sh8000
  };

endpackage

[rtl/core/audio_window_level_extractor.sv]
`timescale 1ns / 1ps
// Sliding-window loudness detector. One sample request is taken per cycle while no window
// completes, no finished level waits and no recompute runs. A sample that completes a window
// launches a token down a row of MAX_WINDOW+1 history cells, one cell per cycle, and the input
// is held while the token crosses the cells of the effective window length. The level is
// registered at the output and a second finished level waits in a holding register. After
// reset and after every configuration write the input is held while a bit-serial unit
// recomputes the sample count modulo the step and the window length modulo the step.
module audio_window_level_extractor #(
  parameter int MAX_WINDOW = 64,
  parameter int MAX_STEP   = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [awle_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                             in_start_req,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [awle_pkg::LEVEL_W-1:0]     out_level,
  input  logic                             cfg_we,
  input  logic [awle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [awle_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int HIST  = MAX_WINDOW + 1;
  localparam int WW    = $clog2(MAX_WINDOW + 1);
  localparam int SW    = $clog2(MAX_STEP + 1);
  localparam int SUM_W = awle_pkg::RANGE_W + $clog2(MAX_WINDOW);
  localparam int CW    = awle_pkg::COUNT_W;
  localparam int RW    = awle_pkg::RANGE_W;
  localparam int LW    = awle_pkg::LEVEL_W;

  localparam logic [2:0] RC_IDLE   = 3'd0;
  localparam logic [2:0] RC_LOAD_N = 3'd1;
  localparam logic [2:0] RC_RUN_N  = 3'd2;
  localparam logic [2:0] RC_LOAD_W = 3'd3;
  localparam logic [2:0] RC_RUN_W  = 3'd4;

  // configuration
  logic [1:0]                 level_mode_r;
  logic [awle_pkg::CFG_W-1:0] window_length_r;
  logic [awle_pkg::CFG_W-1:0] window_step_r;
  logic [WW-1:0]              w_eff;
  logic [SW-1:0]              s_eff;
  logic                       mode_range;
  logic                       mode_diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_mode_r    <= awle_pkg::MODE_MIX;
      window_length_r <= awle_pkg::CFG_W'(11);
      window_step_r   <= awle_pkg::CFG_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        awle_pkg::REG_LEVEL_MODE:    level_mode_r    <= cfg_wdata[1:0];
        awle_pkg::REG_WINDOW_LENGTH: window_length_r <= cfg_wdata;
        awle_pkg::REG_WINDOW_STEP:   window_step_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (window_length_r == '0)               w_eff = WW'(1);
    else if (int'(window_length_r) > MAX_WINDOW) w_eff = WW'(MAX_WINDOW);
    else                                     w_eff = WW'(window_length_r);
    if (window_step_r == '0)                 s_eff = SW'(1);
    else if (int'(window_step_r) > MAX_STEP) s_eff = SW'(MAX_STEP);
    else                                     s_eff = SW'(window_step_r);
    mode_range = (level_mode_r == awle_pkg::MODE_RANGE);
    mode_diff  = (level_mode_r == awle_pkg::MODE_DIFF);
  end

  // count, remainders and their recompute sequencer
  logic [CW-1:0] n_r, n_nxt;
  logic [SW-1:0] rem_n_r, rem_n_nxt;
  logic [SW-1:0] rem_w_r, rem_w_nxt;
  logic [2:0]    rc_state_r, rc_state_nxt;
  logic          div_start;
  logic [CW-1:0] div_dividend;
  logic          div_done;
  logic [SW-1:0] div_rem;

  awle_rem_div #(.DIV_W(SW)) u_rem_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (s_eff),
    .done_r   (div_done),
    .rem_r    (div_rem)
  );

  // wave and output control
  logic          accept;
  logic          launch_r;
  logic          wave_busy;
  logic [CW-1:0] n_eff;
  logic [SW-1:0] rem_eff;
  logic [SW-1:0] rem_w1;
  logic          emit;

  assign accept = in_valid & ~in_stall;

  always_comb begin
    n_eff   = in_start_req ? '0 : n_r;
    rem_eff = in_start_req ? '0 : rem_n_r;
    rem_w1  = (rem_w_r == '0) ? (s_eff - SW'(1)) : (rem_w_r - SW'(1));
    if (mode_range)
      emit = (n_eff >= (CW'(w_eff) - CW'(1))) && (rem_eff == rem_w1);
    else
      emit = (n_eff >= CW'(w_eff)) && (rem_eff == rem_w_r);
  end

  always_comb begin
    rc_state_nxt = rc_state_r;
    rem_n_nxt    = rem_n_r;
    rem_w_nxt    = rem_w_r;
    n_nxt        = n_r;
    div_start    = 1'b0;
    div_dividend = n_r;
    case (rc_state_r)
      RC_LOAD_N: begin
        div_start    = 1'b1;
        rc_state_nxt = RC_RUN_N;
      end
      RC_RUN_N: begin
        if (div_done) begin
          rem_n_nxt    = div_rem;
          rc_state_nxt = RC_LOAD_W;
        end
      end
      RC_LOAD_W: begin
        div_start    = 1'b1;
        div_dividend = CW'(w_eff);
        rc_state_nxt = RC_RUN_W;
      end
      RC_RUN_W: begin
        if (div_done) begin
          rem_w_nxt    = div_rem;
          rc_state_nxt = RC_IDLE;
        end
      end
      default: rc_state_nxt = RC_IDLE;
    endcase
    if (accept) begin
      n_nxt = n_eff + CW'(1);
      if (n_eff == '1 || rem_eff == (s_eff - SW'(1))) rem_n_nxt = '0;
      else                                             rem_n_nxt = rem_eff + SW'(1);
    end
    if (cfg_we) rc_state_nxt = RC_LOAD_N;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_state_r <= RC_LOAD_N;
      n_r        <= '0;
      rem_n_r    <= '0;
      rem_w_r    <= '0;
      launch_r   <= 1'b0;
    end else begin
      rc_state_r <= rc_state_nxt;
      n_r        <= n_nxt;
      rem_n_r    <= rem_n_nxt;
      rem_w_r    <= rem_w_nxt;
      launch_r   <= accept & emit;
    end
  end

  // row of history cells
  awle_pkg::sample_t  hist    [HIST];
  logic [SUM_W-1:0]   sums    [HIST];
  awle_pkg::mm_t      mms     [HIST];
  logic [HIST-1:0]    tok_v;
  logic [HIST-1:0]    fwd_v;
  logic [HIST-1:0]    done_v;
  logic [HIST-1:0]    last_v;

  for (genvar j = 0; j < HIST; j++) begin : g_cell
    awle_pkg::sample_t smp_in;
    awle_pkg::sample_t smp_next;
    logic              tok_in;
    logic [SUM_W-1:0]  sum_in;
    awle_pkg::mm_t     mm_in;

    if (j == 0) begin : g_head
      assign smp_in = in_sample;
      assign tok_in = launch_r;
      assign sum_in = '0;
      assign mm_in  = awle_pkg::MM_INIT;
    end else begin : g_body
      assign smp_in = in_start_req ? '0 : hist[j-1];
      assign tok_in = fwd_v[j-1];
      assign sum_in = sums[j-1];
      assign mm_in  = mms[j-1];
    end

    if (j == HIST - 1) begin : g_tail
      assign smp_next = '0;
    end else begin : g_mid
      assign smp_next = hist[j+1];
    end

    assign last_v[j] = (j == int'(w_eff) - 1);

    awle_cell #(.SUM_W(SUM_W)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (accept),
      .smp_in   (smp_in),
      .smp_next (smp_next),
      .tok_in   (tok_in),
      .sum_in   (sum_in),
      .mm_in    (mm_in),
      .is_last  (last_v[j]),
      .smp_r    (hist[j]),
      .tok_r    (tok_v[j]),
      .tok_fwd  (fwd_v[j]),
      .tok_done (done_v[j]),
      .sum_r    (sums[j]),
      .mm_r     (mms[j])
    );
  end

  assign wave_busy = launch_r | (|tok_v);

  // gather the finished window
  logic              done;
  logic [SUM_W-1:0]  sum_g;
  awle_pkg::mm_t     mm_g;
  logic [RW-1:0]     range0;
  logic [RW-1:0]     range1;
  logic [SUM_W:0]    mix_sum;
  logic [LW-1:0]     level;

  logic [RW-1:0]     prev_range_r;
  logic              any_emit_r;

  always_comb begin
    done  = |done_v;
    sum_g = '0;
    mm_g  = '0;
    for (int j = 0; j < HIST; j++) begin
      sum_g = sum_g | (sums[j] & {SUM_W{done_v[j]}});
      mm_g  = mm_g | (mms[j] & {$bits(awle_pkg::mm_t){done_v[j]}});
    end
    range0  = RW'({mm_g.hi0[awle_pkg::SAMPLE_W-1], mm_g.hi0}
                - {mm_g.lo0[awle_pkg::SAMPLE_W-1], mm_g.lo0});
    range1  = RW'({mm_g.hi1[awle_pkg::SAMPLE_W-1], mm_g.hi1}
                - {mm_g.lo1[awle_pkg::SAMPLE_W-1], mm_g.lo1});
    mix_sum = {1'b0, sum_g} + (SUM_W + 1)'(prev_range_r);
    if (mode_range)                    level = LW'(range0);
    else if (mode_diff || !any_emit_r) level = LW'(sum_g);
    else                               level = LW'(mix_sum >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_range_r <= '0;
      any_emit_r   <= 1'b0;
    end else if (accept && in_start_req) begin
      prev_range_r <= '0;
      any_emit_r   <= 1'b0;
    end else if (done) begin
      any_emit_r <= 1'b1;
      if (!mode_range) prev_range_r <= range1;
    end
  end

  // output register and holding register
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] out_level_r, out_level_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [LW-1:0] pend_level_r, pend_level_nxt;
  logic          out_free;

  always_comb begin
    out_free       = ~out_valid_r | ~out_stall;
    out_valid_nxt  = out_valid_r;
    out_level_nxt  = out_level_r;
    pend_vld_nxt   = pend_vld_r;
    pend_level_nxt = pend_level_r;
    if (out_free) begin
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_level_nxt = pend_level_r;
        pend_vld_nxt  = 1'b0;
      end else if (done) begin
        out_valid_nxt = 1'b1;
        out_level_nxt = level;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (done) begin
      pend_vld_nxt   = 1'b1;
      pend_level_nxt = level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_vld_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_vld_r  <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_level_r  <= out_level_nxt;
    pend_level_r <= pend_level_nxt;
  end

  assign in_stall  = wave_busy | pend_vld_r | (rc_state_r != RC_IDLE);
  assign out_valid = out_valid_r;
  assign out_level = out_level_r;

  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_v))
    else $error("more than one token in the cell row");

  assert property (@(posedge clk) disable iff (!rst_n)
    (rc_state_r == RC_IDLE) |-> (rem_n_r < s_eff))
    else $error("count remainder out of step range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (done && out_valid_r && out_stall) |=> pend_vld_r)
    else $error("finished level lost while output stalled");

  assert property (@(posedge clk) disable iff (!rst_n) pend_vld_r |-> out_valid_r)
    else $error("holding register full with output empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit) |=> (launch_r && in_stall))
    else $error("window completion did not launch a token");

endmodule

[rtl/core/awle_cell.sv]
`timescale 1ns / 1ps
module awle_cell #(
  parameter int SUM_W = 23
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift,
  input  awle_pkg::sample_t   smp_in,
  input  awle_pkg::sample_t   smp_next,
  input  logic                tok_in,
  input  logic [SUM_W-1:0]    sum_in,
  input  awle_pkg::mm_t       mm_in,
  input  logic                is_last,
  output awle_pkg::sample_t   smp_r,
  output logic                tok_r,
  output logic                tok_fwd,
  output logic                tok_done,
  output logic [SUM_W-1:0]    sum_r,
  output awle_pkg::mm_t       mm_r
);

  logic signed [awle_pkg::RANGE_W-1:0] diff;
  logic [awle_pkg::RANGE_W-1:0]        abs_diff;
  logic [SUM_W-1:0]                    sum_nxt;
  awle_pkg::mm_t                       mm_nxt;

  always_comb begin
    diff     = {smp_r[awle_pkg::SAMPLE_W-1], smp_r}
             - {smp_next[awle_pkg::SAMPLE_W-1], smp_next};
    abs_diff = diff[awle_pkg::RANGE_W-1] ? awle_pkg::RANGE_W'(-diff)
                                         : awle_pkg::RANGE_W'(diff);
    sum_nxt  = sum_in + SUM_W'(abs_diff);
    mm_nxt   = mm_in;
    if (smp_r < mm_in.lo0) mm_nxt.lo0 = smp_r;
    if (smp_r > mm_in.hi0) mm_nxt.hi0 = smp_r;
    if (smp_next < mm_in.lo1) mm_nxt.lo1 = smp_next;
    if (smp_next > mm_in.hi1) mm_nxt.hi1 = smp_next;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
      tok_r <= 1'b0;
    end else begin
      if (shift) smp_r <= smp_in;
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      sum_r <= sum_nxt;
      mm_r  <= mm_nxt;
    end
  end

  assign tok_fwd  = tok_r & ~is_last;
  assign tok_done = tok_r & is_last;

endmodule

[rtl/core/awle_rem_div.sv]
`timescale 1ns / 1ps
module awle_rem_div #(
  parameter int DIV_W = 7
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [awle_pkg::COUNT_W-1:0] dividend,
  input  logic [DIV_W-1:0]             divisor,
  output logic                         done_r,
  output logic [DIV_W-1:0]             rem_r
);

  localparam int CNT_W = $clog2(awle_pkg::COUNT_W);

  logic                         busy_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [awle_pkg::COUNT_W-1:0] dvd_r;
  logic [DIV_W-1:0]             divisor_r;
  logic [DIV_W:0]               part;
  logic [DIV_W:0]               part_sub;
  logic [DIV_W-1:0]             rem_step;

  always_comb begin
    part     = {rem_r, dvd_r[awle_pkg::COUNT_W-1]};
    part_sub = part - {1'b0, divisor_r};
    rem_step = (part >= {1'b0, divisor_r}) ? DIV_W'(part_sub) : DIV_W'(part);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(awle_pkg::COUNT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r     <= dividend;
      divisor_r <= divisor;
      rem_r     <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[awle_pkg::COUNT_W-2:0], 1'b0};
      rem_r <= rem_step;
    end
  end

endmodule
